// ----- rtl/core/cats_pkg.sv -----
// Shared types, character codes and helper functions for the comment-aware token search.
package cats_pkg;

	localparam int TOKEN_BYTES = 16;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	typedef enum logic [1:0] {
		CFG_TOKEN_LENGTH = 2'd0,
		CFG_BYTES_LOW    = 2'd1,
		CFG_BYTES_HIGH   = 2'd2
	} cfg_index_t;

	typedef enum logic [4:0] {
		MODE_CODE  = 5'b00001,
		MODE_LINE  = 5'b00010,
		MODE_BLOCK = 5'b00100,
		MODE_STR   = 5'b01000,
		MODE_CHR   = 5'b10000
	} lex_mode_t;

	// One history entry as it moves from cell to cell.
	typedef struct packed {
		logic [7:0] data;
		logic       start_ok;
		logic       valid;
	} hist_t;

	// Role of one cell for the current token length.
	typedef struct packed {
		logic       in_now;
		logic       start_now;
		logic       before_now;
		logic       in_end;
		logic       start_end;
		logic       before_end;
		logic [7:0] exp_now;
		logic [7:0] exp_end;
	} cell_sel_t;

	typedef struct packed {
		logic now_ok;
		logic end_ok;
	} cell_res_t;

	typedef struct packed {
		logic start_cur;
		logic start_fix;
	} lex_out_t;

	function automatic logic is_ident(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
	endfunction

	function automatic logic [7:0] tok_byte(input logic [8*TOKEN_BYTES-1:0] tok,
	                                        input logic [3:0] idx);
		return tok[{idx, 3'b000} +: 8];
	endfunction

endpackage

// ----- rtl/core/comment_aware_token_search.sv -----
// Top level of the comment-aware whole-word token search.
// The block takes C source text one byte per request on the slave stream and reports, on the
// byte marked by tlast, whether the configured token occurs as a whole word whose first byte was
// seen as code (not inside a comment, string or character literal). It accepts one byte every
// clock cycle unless the slave side stalls: the lexer updates its mode and a row of MAX_TOKEN+1
// history cells shifts by one entry per byte, each cell comparing its byte with the token byte
// that its position calls for, and there is no per-file overhead. The found flag appears in
// the master output register on the cycle after the last byte is accepted; the slave side only
// stalls while that register holds a result that has not been taken. After the last byte all
// search state returns to its reset value, ready for the next file. The configuration port writes
// the token length (0 acts as 1, values above MAX_TOKEN act as MAX_TOKEN) and the token bytes,
// and must only be used while no file is in progress.
module comment_aware_token_search #(
	parameter int MAX_TOKEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] token_found, [7:1] zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import cats_pkg::*;

	localparam int HIST = MAX_TOKEN + 1;
	localparam int CW   = $clog2(MAX_TOKEN + 3);

	logic [4:0]               token_length_q;
	logic [63:0]              token_bytes_low_q;
	logic [63:0]              token_bytes_high_q;
	logic [8*TOKEN_BYTES-1:0] tok;
	logic [CW-1:0]            len;

	logic       s_fire;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       found_q;
	logic       hit_now;
	logic       hit_end;
	logic       found_d;

	lex_out_t        lex;
	hist_t           hist_out [HIST];
	cell_res_t       cell_res [HIST];
	logic [HIST-1:0] now_vec;
	logic [HIST-1:0] end_vec;
	logic [HIST-1:0] valid_vec;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_length_q     <= 5'd1;
			token_bytes_low_q  <= '0;
			token_bytes_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_TOKEN_LENGTH: token_length_q     <= cfg_data[4:0];
				CFG_BYTES_LOW:    token_bytes_low_q  <= cfg_data;
				CFG_BYTES_HIGH:   token_bytes_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign tok = {token_bytes_high_q, token_bytes_low_q};

	// Effective token length, clamped into 1..MAX_TOKEN.
	always_comb begin
		if (token_length_q == 5'd0) len = CW'(1);
		else if (token_length_q > 5'(MAX_TOKEN)) len = CW'(MAX_TOKEN);
		else len = CW'(token_length_q);
	end

	// A new byte is taken whenever the output register is free or being emptied.
	assign s_tready = !m_tvalid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	cats_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s_fire),
		.last   (s_tlast),
		.c      (s_tdata),
		.lex    (lex)
	);

	// Cell k holds the byte that arrived k+1 requests ago. For a match that ends one byte
	// back, cell k carries token byte len-1-k; for a match that ends at the current last
	// byte, it carries token byte len-2-k.
	for (genvar k = 0; k < HIST; k++) begin : g_cell
		cell_sel_t     sel;
		hist_t         shift_in;
		logic          fix;
		logic [CW-1:0] idx_now;
		logic [CW-1:0] idx_end;

		assign idx_now        = len - CW'(k + 1);
		assign idx_end        = len - CW'(k + 2);
		assign sel.in_now     = CW'(k) < len;
		assign sel.start_now  = CW'(k + 1) == len;
		assign sel.before_now = CW'(k) == len;
		assign sel.in_end     = CW'(k + 1) < len;
		assign sel.start_end  = CW'(k + 2) == len;
		assign sel.before_end = CW'(k + 1) == len;
		assign sel.exp_now    = tok_byte(tok, 4'(idx_now));
		assign sel.exp_end    = tok_byte(tok, 4'(idx_end));

		if (k == 0) begin : g_head
			assign shift_in = '{data: s_tdata, start_ok: lex.start_cur, valid: 1'b1};
			assign fix      = lex.start_fix;
		end else begin : g_body
			assign shift_in = hist_out[k-1];
			assign fix      = 1'b0;
		end

		cats_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (s_fire),
			.clear     (s_tlast),
			.start_fix (fix),
			.shift_in  (shift_in),
			.sel       (sel),
			.shift_out (hist_out[k]),
			.res       (cell_res[k])
		);

		assign now_vec[k]   = cell_res[k].now_ok;
		assign end_vec[k]   = cell_res[k].end_ok;
		assign valid_vec[k] = hist_out[k].valid;
	end

	// Match that ended on the previous byte: the current byte must not extend the word.
	assign hit_now = !is_ident(s_tdata) && (&now_vec);

	// Match that ends on the final byte of the file itself.
	assign hit_end = s_tlast && (s_tdata == tok_byte(tok, 4'(len - CW'(1)))) &&
	                 (len != CW'(1) || lex.start_cur) && (&end_vec);

	assign found_d = found_q || hit_now || hit_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				found_q <= s_tlast ? 1'b0 : found_d;
			end
			if (s_fire && s_tlast) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && s_tlast) begin
			m_tdata_q <= {7'b0, found_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// A waiting result must hold off new bytes.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while result pending");

	// The end of a file empties the whole history.
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_tlast) |=> (valid_vec == '0 && !found_q))
		else $error("history not cleared after last byte");

	// Any other byte enters the head cell.
	a_head_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && !s_tlast) |=> valid_vec[0])
		else $error("head cell not filled");

	// Valid entries form an unbroken run from the head of the row.
	if (HIST > 1) begin : g_contig
		a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
			(valid_vec[HIST-1:1] & ~valid_vec[HIST-2:0]) == '0)
			else $error("gap in history valid bits");
	end

endmodule

// ----- rtl/core/cats_cell.sv -----
// One history cell: holds a byte with its start and valid flags and checks it against the token.
module cats_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                clear,
	input  logic                start_fix,
	input  cats_pkg::hist_t     shift_in,
	input  cats_pkg::cell_sel_t sel,
	output cats_pkg::hist_t     shift_out,
	output cats_pkg::cell_res_t res
);
	import cats_pkg::*;

	logic [7:0] data_q;
	logic       start_q;
	logic       valid_q;
	logic       start_eff;
	logic       ident_here;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			valid_q <= 1'b0;
		end else if (step) begin
			start_q <= clear ? 1'b0 : shift_in.start_ok;
			valid_q <= clear ? 1'b0 : shift_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			data_q <= shift_in.data;
		end
	end

	// A slash held back in code becomes a legal start once the next byte rules out a comment.
	assign start_eff  = start_q | start_fix;
	assign ident_here = valid_q & is_ident(data_q);

	assign shift_out = '{data: data_q, start_ok: start_eff, valid: valid_q};

	assign res.now_ok = (!sel.in_now || data_q == sel.exp_now) &&
	                    (!sel.start_now || (valid_q && start_eff)) &&
	                    (!sel.before_now || !ident_here);
	assign res.end_ok = (!sel.in_end || data_q == sel.exp_end) &&
	                    (!sel.start_end || (valid_q && start_eff)) &&
	                    (!sel.before_end || !ident_here);

endmodule

// ----- rtl/core/cats_lexer.sv -----
// Lexer mode tracker that decides which bytes may start a token match.
module cats_lexer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               last,
	input  logic [7:0]         c,
	output cats_pkg::lex_out_t lex
);
	import cats_pkg::*;

	lex_mode_t mode_q, mode_d;
	logic      slash_q, slash_d;
	logic      skip_q, skip_d;
	logic      star_q, star_d;
	logic      as_code;

	always_comb begin
		mode_d        = mode_q;
		slash_d       = slash_q;
		skip_d        = skip_q;
		star_d        = star_q;
		as_code       = 1'b0;
		lex.start_cur = 1'b0;
		lex.start_fix = 1'b0;
		if (skip_q) begin
			skip_d = 1'b0;
		end else if (slash_q) begin
			slash_d = 1'b0;
			if (c == CH_SLASH) begin
				mode_d = MODE_LINE;
			end else if (c == CH_STAR) begin
				mode_d = MODE_BLOCK;
				star_d = 1'b0;
			end else begin
				lex.start_fix = 1'b1;
				as_code       = 1'b1;
			end
		end else begin
			unique case (mode_q)
				MODE_LINE: begin
					if (c == CH_NL) mode_d = MODE_CODE;
				end
				MODE_BLOCK: begin
					if (star_q && c == CH_SLASH) begin
						mode_d = MODE_CODE;
						star_d = 1'b0;
					end else begin
						star_d = (c == CH_STAR);
					end
				end
				MODE_STR: begin
					if (c == CH_BSLASH) skip_d = 1'b1;
					else if (c == CH_DQUOTE) mode_d = MODE_CODE;
				end
				MODE_CHR: begin
					if (c == CH_BSLASH) skip_d = 1'b1;
					else if (c == CH_SQUOTE) mode_d = MODE_CODE;
				end
				default: begin
					as_code = 1'b1;
				end
			endcase
		end
		if (as_code) begin
			if (c == CH_SLASH) begin
				if (last) lex.start_cur = 1'b1;
				else slash_d = 1'b1;
			end else if (c == CH_DQUOTE) begin
				mode_d = MODE_STR;
			end else if (c == CH_SQUOTE) begin
				mode_d = MODE_CHR;
			end else begin
				lex.start_cur = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_CODE;
			slash_q <= 1'b0;
			skip_q  <= 1'b0;
			star_q  <= 1'b0;
		end else if (step) begin
			if (last) begin
				mode_q  <= MODE_CODE;
				slash_q <= 1'b0;
				skip_q  <= 1'b0;
				star_q  <= 1'b0;
			end else begin
				mode_q  <= mode_d;
				slash_q <= slash_d;
				skip_q  <= skip_d;
				star_q  <= star_d;
			end
		end
	end

endmodule
